@@ rtl/core/bvs_pkg.sv @@
// Shared widths, operation and status codes for the bounded vector store.
package bvs_pkg;

    localparam int KIND_W    = 3;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 11;
    localparam int DEPTH_DEF = 1024;

    typedef logic [KIND_W-1:0]        t_kind;
    typedef logic [IDX_W-1:0]         t_index;
    typedef logic signed [VAL_W-1:0]  t_value;
    typedef logic [STAT_W-1:0]        t_status;
    typedef logic [CNT_W-1:0]         t_count;

    localparam t_kind OP_PUSH   = 3'd0;
    localparam t_kind OP_POP    = 3'd1;
    localparam t_kind OP_READ   = 3'd2;
    localparam t_kind OP_WRITE  = 3'd3;
    localparam t_kind OP_REMOVE = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage

@@ rtl/core/bvs_if.sv @@
// Command and response channel interfaces of the bounded vector store.
interface bvs_cmd_if;
    import bvs_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  kind;
    t_index index;
    t_value value;

    modport source (output valid, output kind, output index, output value, input ready);
    modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

interface bvs_rsp_if;
    import bvs_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_value  read_value;
    t_count  count;

    modport source (output valid, output status, output read_value, output count, input ready);
    modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

@@ rtl/core/bvs_ram.sv @@
// Element store: one write port, one read port, registered read data.
module bvs_ram #(
    parameter int DEPTH = bvs_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [bvs_pkg::VAL_W-1:0]        i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [bvs_pkg::VAL_W-1:0]        o_rdata
);
    import bvs_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bounded_vector_store.sv @@
// Top level of the bounded vector store: operation sequencer around the element RAM.
//
// Usage:
//   i_cmd carries one operation per transaction: push, pop, read, write or
//   remove at an index. o_rsp returns exactly one transaction per operation
//   with a status (ok, out of range / empty, full), the word read or popped
//   (zero otherwise) and the element count after the operation.
//   With the response register free, a command passes from S_IDLE to S_FIN,
//   via S_RM for a remove walk, and S_FIN loads the response register.
//   A new command is taken only after the previous result has been handed
//   to the output register. In a remove walk the single RAM moves one
//   element down per cycle, reading the next entry while writing the
//   previous one.
//   Reset clears the element count and the response valid flag; the RAM is
//   not cleared, since every entry below the count was written by a push.
//   While the receiver stalls, a finished response waits in the output
//   register; one more command is still taken and its result holds in the
//   sequencer until the output register frees up.
//   Accesses never overlap on one entry: commands are handled one at a time
//   and the remove walk writes two entries below the one it reads.
module bounded_vector_store #(
    parameter int DEPTH = bvs_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bvs_cmd_if.sink   i_cmd,
    bvs_rsp_if.source o_rsp
);
    import bvs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam int XO = (CW > CNT_W) ? CW : CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RM   = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_ptr, n_ptr;
    t_status          r_status, n_status;
    logic             r_use_mem, n_use_mem;
    logic             r_ovalid, n_ovalid;
    t_status          r_ostatus, n_ostatus;
    t_value           r_oval, n_oval;
    t_count           r_ocnt, n_ocnt;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;

    logic             acc;
    logic [XW-1:0]    idx_x, cnt_x, rm_first;
    logic [CW-1:0]    cnt_dec, ptr_next;
    logic [XO-1:0]    cnt_o;
    logic             idx_ok, full, empty, rm_more;

    bvs_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign acc              = i_cmd.valid && i_cmd.ready;

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_ostatus;
    assign o_rsp.read_value = r_oval;
    assign o_rsp.count      = r_ocnt;

    assign idx_x    = XW'(i_cmd.index);
    assign cnt_x    = XW'(r_cnt);
    assign idx_ok   = idx_x < cnt_x;
    // Only used when the index is in range, so it cannot wrap.
    assign rm_first = idx_x + XW'(1);
    assign full     = r_cnt >= CW'(DEPTH);
    assign empty    = (r_cnt == '0);
    assign cnt_dec  = r_cnt - CW'(1);
    assign ptr_next = CW'(r_ptr) + CW'(1);
    assign rm_more  = ptr_next < r_cnt;
    assign cnt_o    = XO'(r_cnt);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_status  = r_status;
        n_use_mem = r_use_mem;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_oval    = r_oval;
        n_ocnt    = r_ocnt;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_ptr;
        ram_raddr = r_ptr;
        ram_wdata = ram_rdata;

        // Drop the response once the receiver takes it.
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state   = S_FIN;
                    n_status  = ST_OK;
                    n_use_mem = 1'b0;
                    case (i_cmd.kind)
                        OP_PUSH: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_cnt[AW-1:0];
                                ram_wdata = i_cmd.value;
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (empty) begin
                                n_status = ST_RANGE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = cnt_dec[AW-1:0];
                                n_cnt     = cnt_dec;
                                n_use_mem = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (!idx_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = idx_x[AW-1:0];
                                n_use_mem = 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            if (!idx_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = idx_x[AW-1:0];
                                ram_wdata = i_cmd.value;
                            end
                        end
                        OP_REMOVE: begin
                            if (!idx_ok) begin
                                n_status = ST_RANGE;
                            end else if (rm_first < cnt_x) begin
                                // Start the walk: fetch the element above the hole.
                                ram_re    = 1'b1;
                                ram_raddr = rm_first[AW-1:0];
                                n_ptr     = rm_first[AW-1:0];
                                n_state   = S_RM;
                            end else begin
                                // Last element: only the count drops.
                                n_cnt = cnt_dec;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_RM: begin
                // Move the fetched element down one place; fetch the next one.
                ram_we    = 1'b1;
                ram_waddr = r_ptr - AW'(1);
                ram_wdata = ram_rdata;
                if (rm_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_next[AW-1:0];
                    n_ptr     = ptr_next[AW-1:0];
                end else begin
                    n_cnt   = cnt_dec;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Hand the result to the output register once it is free.
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oval    = r_use_mem ? t_value'(ram_rdata) : t_value'('0);
                    n_ocnt    = cnt_o[CNT_W-1:0];
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_status  <= n_status;
        r_use_mem <= n_use_mem;
        r_ostatus <= n_ostatus;
        r_oval    <= n_oval;
        r_ocnt    <= n_ocnt;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("element count beyond capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write target the same entry");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RM) |-> (CW'(r_ptr) < r_cnt))
        else $error("remove walk past the last element");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_cmd.kind == OP_PUSH && !full) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("push did not grow the vector");

    a_cnt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!acc && r_state != S_RM) |=> $stable(r_cnt))
        else $error("count changed without an operation");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the bounded vector store: random operations against a shadow vector.
`timescale 1ns / 1ps

module tb_top;
    import bvs_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // One response as the block should return it.
    typedef struct packed {
        t_status status;
        t_value  read_value;
        t_count  count;
    } t_rsp;

    // Shadow copy of the vector: predicts each response from the accepted
    // commands and holds the responses still owed by the block.
    class vector_scoreboard;
        t_value      shadow_elems [DEPTH];
        int unsigned held;
        t_rsp        awaited [$];
        int unsigned fails;

        function new();
            held  = 0;
            fails = 0;
        endfunction

        function void flag(string what, t_rsp want, t_rsp got);
            fails++;
            if (fails <= 10) begin
                $display({"mismatch: %s; expected status=%0d value=%0d count=%0d,",
                          " got status=%0d value=%0d count=%0d"},
                         what, want.status, $signed(want.read_value), want.count,
                         got.status, $signed(got.read_value), got.count);
            end
        endfunction

        // Apply one accepted command to the shadow vector and queue its response.
        function void note_command(t_kind kind, t_index idx, t_value word);
            t_rsp r;
            r.status     = ST_RANGE;
            r.read_value = '0;
            case (kind)
                OP_PUSH: begin
                    if (held >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        shadow_elems[held] = word;
                        held++;
                        r.status = ST_OK;
                    end
                end
                OP_POP: begin
                    if (held != 0) begin
                        held--;
                        r.status     = ST_OK;
                        r.read_value = shadow_elems[held];
                    end
                end
                OP_READ: begin
                    if (idx < held) begin
                        r.status     = ST_OK;
                        r.read_value = shadow_elems[idx];
                    end
                end
                OP_WRITE: begin
                    if (idx < held) begin
                        shadow_elems[idx] = word;
                        r.status = ST_OK;
                    end
                end
                OP_REMOVE: begin
                    if (idx < held) begin
                        for (int i = idx; i + 1 < held; i++)
                            shadow_elems[i] = shadow_elems[i + 1];
                        held--;
                        r.status = ST_OK;
                    end
                end
                default: ;
            endcase
            r.count = t_count'(held);
            awaited.push_back(r);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                flag("response with nothing pending", '0, got);
            end else begin
                want = awaited.pop_front();
                if (got.status !== want.status || got.read_value !== want.read_value ||
                    got.count !== want.count)
                    flag("field mismatch", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic calm;     // high: neither side idles

    vector_scoreboard sb;

    bvs_cmd_if cmd_bus ();
    bvs_rsp_if rsp_bus ();

    bounded_vector_store #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_bus),
        .o_rsp  (rsp_bus)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: drop ready in about a third of the cycles unless calm.
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            rsp_bus.ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    // Advance one clock and sample both handshakes in a fixed order. Check
    // the response first: it can never belong to the command taken at the
    // same edge, so the order keeps the scoreboard deterministic.
    task automatic tick();
        t_rsp got;
        @(posedge clk);
        if (rsp_bus.valid && rsp_bus.ready) begin
            got.status     = rsp_bus.status;
            got.read_value = rsp_bus.read_value;
            got.count      = rsp_bus.count;
            sb.check_response(got);
        end
        if (cmd_bus.valid && cmd_bus.ready)
            sb.note_command(cmd_bus.kind, cmd_bus.index, cmd_bus.value);
    endtask

    // Offer one command, with random idle cycles ahead of it, and hold it
    // until the transaction completes. Valid stays high between back-to-back
    // commands, so it gets a single assignment per step.
    task automatic send_op(t_kind kind, t_index idx, t_value word);
        while (!calm && $urandom_range(99) < 32) begin
            cmd_bus.valid <= 1'b0;
            tick();
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.kind  <= kind;
        cmd_bus.index <= idx;
        cmd_bus.value <= word;
        do tick(); while (!cmd_bus.ready);
    endtask

    // Random word, biased toward the signed extremes, zero and minus one.
    function automatic t_value rand_word();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return t_value'($urandom);
        endcase
    endfunction

    // Mostly a valid position in the current vector, sometimes any index.
    function automatic t_index rand_index();
        if (sb.held > 0 && $urandom_range(99) < 80)
            return t_index'($urandom_range(sb.held - 1));
        return t_index'($urandom);
    endfunction

    // Push with the given weight; the rest spread over the other operations
    // and the unused codes above remove.
    function automatic t_kind rand_kind(int push_pct);
        int r;
        if ($urandom_range(99) < push_pct)
            return OP_PUSH;
        r = $urandom_range(99);
        if (r < 25) return OP_POP;
        if (r < 45) return OP_READ;
        if (r < 65) return OP_WRITE;
        if (r < 88) return OP_REMOVE;
        return t_kind'(OP_REMOVE + $urandom_range(3, 1));
    endfunction

    task automatic send_random(int push_pct);
        t_kind kind;
        kind = rand_kind(push_pct);
        send_op(kind, rand_index(), rand_word());
    endtask

    initial begin
        int full_hits;
        int n;

        cmd_bus.valid = 1'b0;
        cmd_bus.kind  = OP_PUSH;
        cmd_bus.index = '0;
        cmd_bus.value = '0;
        rst_n = 1'b0;
        calm  = 1'b0;
        sb    = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        tick();

        // Directed: pop, read, write and remove on an empty vector fail with range status.
        send_op(OP_POP,    '0, '0);
        send_op(OP_READ,   '0, '0);
        send_op(OP_WRITE,  '0, 32'sh1234_5678);
        send_op(OP_REMOVE, '0, '0);

        // Fill with the extreme words, then read inside and just past the end.
        send_op(OP_PUSH, '0, 32'sh7FFF_FFFF);
        send_op(OP_PUSH, '1, 32'sh8000_0000);
        send_op(OP_PUSH, '0, '0);
        send_op(OP_PUSH, '0, '1);
        send_op(OP_READ, '0, '0);
        send_op(OP_READ, 10'd3, '0);
        send_op(OP_READ, 10'd4, '0);
        send_op(OP_READ, '1, '0);
        send_op(OP_WRITE, 10'd1, 32'sh5A5A_A5A5);
        send_op(OP_WRITE, '1, 32'sh0F0F_0F0F);

        // Remove at the front shifts the rest down; remove of the last one
        // only drops the count.
        send_op(OP_REMOVE, '0, '0);
        send_op(OP_REMOVE, 10'd2, '0);

        // Unused codes change nothing.
        send_op(t_kind'(OP_REMOVE + 1), '1, '1);
        send_op(t_kind'(OP_REMOVE + 2), '0, 32'sh8000_0000);
        send_op(t_kind'(OP_REMOVE + 3), '1, 32'sh7FFF_FFFF);

        // Pop what is left, then once more on the empty vector.
        send_op(OP_POP, '0, '0);
        send_op(OP_POP, '0, '0);
        send_op(OP_POP, '0, '0);

        // Churn at a small count.
        repeat (150) send_random(30);

        // Grow to full and keep hitting the full status; no idling on either
        // side for the first stretch.
        full_hits = 0;
        n = 0;
        while (full_hits < 12 && n < 1400) begin
            calm <= (n < 400);
            if (sb.held >= DEPTH && $urandom_range(99) < 93)
                full_hits++;
            send_random(93);
            n++;
        end
        calm <= 1'b0;

        // Mixed traffic near full, long remove walks included.
        repeat (200) send_random(20);

        cmd_bus.valid <= 1'b0;

        // Drain the outstanding responses, then watch for strays.
        while (sb.awaited.size() != 0) tick();
        repeat (20) tick();

        if (sb.fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
